/* rtl/bmos_pkg.sv */
// Package for the block median filter: sizes, types and status structs.
`timescale 1ns / 1ps
package bmos_pkg;

    // Samples held per window
    localparam int WINDOW     = 16;
    localparam int SAMPLE_W   = 24;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((MEDIAN_W + 7) / 8) * 8;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [MEDIAN_W-1:0] t_median;
    typedef logic [CNT_W-1:0]    t_count;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Back-end status
    typedef struct packed {
        t_count count;
        logic   store_full;
    } t_back_stat;

endpackage

/* rtl/block_median_of_samples_core.sv */
// Top level of the block median filter over interval samples.
`timescale 1ns / 1ps
// Takes one interval sample per beat (ms, 8 fractional bits); zero samples are
// dropped. Positive samples are kept sorted in a row of 16 cells, each sample
// inserted by a registered update of the row. When a sample arrives with the
// window full, the block sends the median (sum of the two middle entries, 9
// fractional bits), then restarts the window with that sample. Throughput is
// one beat per cycle while the queue has room and no result is held back; a
// sample passes the front register and the four-entry queue on its way to
// insertion. A result sits in an output register, and the back end stalls
// only when a new result is due while the previous one has not been taken.
module block_median_of_samples_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [bmos_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // [23:0] interval
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [bmos_pkg::M_TDATA_W-1:0]  o_m_axis_tdata   // [24:0] median_value
);

    bmos_pkg::t_fifo_stat fifo_stat;
    bmos_pkg::t_back_stat back_stat;
    logic                 push;
    bmos_pkg::t_sample    push_data;
    logic                 pop;
    bmos_pkg::t_sample    pop_data;

    bmos_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_fifo_stat     (fifo_stat),
        .o_push          (push),
        .o_push_data     (push_data)
    );

    bmos_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (fifo_stat)
    );

    bmos_sorter u_sorter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fifo_stat     (fifo_stat),
        .i_sample        (pop_data),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_stat          (back_stat)
    );

`ifndef NO_ASSERTIONS
    // Window fill never runs past its size
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.count <= bmos_pkg::CNT_W'(bmos_pkg::WINDOW))
        else $error("window fill beyond size");

    // A fresh result always restarts the window with one sample
    a_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> back_stat.count == bmos_pkg::CNT_W'(1))
        else $error("result without window restart");

    // Queue cannot be full and empty at once
    a_fifo_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue flags inconsistent");
`endif

endmodule

/* rtl/bmos_front.sv */
// Front end: takes input beats, drops zero samples, pushes the rest to the queue.
`timescale 1ns / 1ps
module bmos_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [bmos_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [23:0] interval
    input  bmos_pkg::t_fifo_stat        i_fifo_stat,
    output logic                        o_push,
    output bmos_pkg::t_sample           o_push_data
);

    logic              r_valid;
    logic              n_valid;
    bmos_pkg::t_sample r_sample;
    logic              accept;
    bmos_pkg::t_sample in_sample;

    assign in_sample       = i_s_axis_tdata[bmos_pkg::SAMPLE_W-1:0];
    assign o_push          = r_valid && !i_fifo_stat.full;
    assign o_s_axis_tready = !r_valid || !i_fifo_stat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push_data     = r_sample;

    // Only positive samples are held for the queue
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = (in_sample != '0);
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= in_sample;
        end
    end

endmodule

/* rtl/bmos_fifo.sv */
// Short queue of samples between front end and sorting back end.
`timescale 1ns / 1ps
module bmos_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bmos_pkg::t_sample    i_push_data,
    input  logic                 i_pop,
    output bmos_pkg::t_sample    o_pop_data,
    output bmos_pkg::t_fifo_stat o_stat
);

    bmos_pkg::t_sample                r_mem [bmos_pkg::FIFO_DEPTH];
    logic [bmos_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [bmos_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [bmos_pkg::FIFO_PTR_W:0]    r_fill;
    logic [bmos_pkg::FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [bmos_pkg::FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [bmos_pkg::FIFO_PTR_W:0]    n_fill;
    logic                             do_push;
    logic                             do_pop;

    assign o_stat.full  = (r_fill == (bmos_pkg::FIFO_PTR_W + 1)'(bmos_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/bmos_sorter.sv */
// Back end: row of sorting cells, median of a full window, output register.
`timescale 1ns / 1ps
module bmos_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmos_pkg::t_fifo_stat        i_fifo_stat,
    input  bmos_pkg::t_sample           i_sample,
    output logic                        o_pop,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [bmos_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [24:0] median_value
    output bmos_pkg::t_back_stat        o_stat
);

    localparam int W = bmos_pkg::WINDOW;

    bmos_pkg::t_sample r_cell [W];
    bmos_pkg::t_sample n_cell [W];
    logic [W-1:0]      cell_we;
    logic [W-1:0]      gtx;
    bmos_pkg::t_count  r_count;
    bmos_pkg::t_count  n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    bmos_pkg::t_median r_out_data;
    bmos_pkg::t_median median;
    logic              full;
    logic              out_free;
    logic              emit;

    assign full     = (r_count == bmos_pkg::CNT_W'(W));
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_pop    = !i_fifo_stat.empty && (!full || out_free);
    assign emit     = o_pop && full;

    assign o_stat.count      = r_count;
    assign o_stat.store_full = full;

    // Each cell compares the new sample with its own entry; empty cells count as larger
    for (genvar i = 0; i < W; i++) begin : g_cell
        assign gtx[i] = (bmos_pkg::CNT_W'(i) < r_count) ? (r_cell[i] > i_sample) : 1'b1;
        if (i == 0) begin : g_first
            assign cell_we[i] = o_pop && (full || gtx[i]);
        end else begin : g_rest
            assign cell_we[i] = o_pop && !full && gtx[i]
                                && (bmos_pkg::CNT_W'(i) <= r_count);
        end
    end

    // Shift up from the neighbour below, or take the sample at the insert point
    always_comb begin
        n_cell[0] = i_sample;
        for (int k = 1; k < W; k++) begin
            n_cell[k] = gtx[k-1] ? r_cell[k-1] : i_sample;
        end
    end

    // Cell row update
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < W; k++) begin
            if (cell_we[k]) begin
                r_cell[k] <= n_cell[k];
            end
        end
    end

    // Middle of the sorted row, one extra fractional bit
    if ((W % 2) == 0) begin : g_even
        assign median = bmos_pkg::MEDIAN_W'(r_cell[W/2-1]) + bmos_pkg::MEDIAN_W'(r_cell[W/2]);
    end else begin : g_odd
        assign median = {r_cell[W/2], 1'b0};
    end

    // Fill count and result handshake
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_count     = bmos_pkg::CNT_W'(1);
            n_out_valid = 1'b1;
        end else begin
            if (o_pop) begin
                n_count = r_count + 1'b1;
            end
            if (i_m_axis_tready) begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= median;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = bmos_pkg::M_TDATA_W'(r_out_data);

endmodule
